### rtl/core/fsbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbs_pkg
// Shared types and constants for the frame sort block.
// ----------------------------------------------------------------------------
package fsbs_pkg;

    localparam int MAX_FRAMES    = 16;
    localparam int PAYLOAD_BYTES = 5;

    localparam int ID_W   = 8;
    localparam int PLD_W  = 40;
    localparam int LEN_W  = 3;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

    // packed stream words, padded to whole bytes
    localparam int DATA_BITS = ID_W + PLD_W + LEN_W;
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

    // bits above PAYLOAD_BYTES bytes are cleared on store
    localparam logic [PLD_W-1:0] PAYLOAD_MASK =
        (PAYLOAD_BYTES * 8 >= PLD_W) ? {PLD_W{1'b1}}
                                     : ((PLD_W'(1) << (PAYLOAD_BYTES * 8)) - PLD_W'(1));

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PLD_W-1:0]  payload;
        logic [LEN_W-1:0]  length;
    } entry_t;

    typedef struct packed {
        logic insert;   // new frame broadcast to all cells
        logic shift;    // whole row moves one place toward cell 0
    } cell_ctrl_t;

endpackage

### rtl/core/fsbs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbs_cell
// One slot of the insertion row: holds a frame, compares against the
// broadcast frame, takes from its left neighbor on insert and from its
// right neighbor on unload.
// ----------------------------------------------------------------------------
module fsbs_cell
    import fsbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  logic       left_take,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       take
);

    logic              valid_reg;
    logic              valid_next;
    logic [ID_W-1:0]   id_reg;
    logic [PLD_W-1:0]  payload_reg;
    logic [LEN_W-1:0]  length_reg;
    entry_t            entry_next;

    assign entry = '{valid: valid_reg, id: id_reg, payload: payload_reg, length: length_reg};

    // empty slots count as larger than any id; strict compare keeps arrival order
    assign take = !valid_reg || (id_reg > new_entry.id);

    always_comb
    begin
        entry_next = entry;
        if (ctrl.shift)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.insert && take)
        begin
            entry_next = left_take ? left_entry : new_entry;
        end
        valid_next = entry_next.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= entry_next.id;
        payload_reg <= entry_next.payload;
        length_reg  <= entry_next.length;
    end

endmodule

### rtl/core/frame_sort_by_sequence_id.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_sort_by_sequence_id
// Collects a batch of frames into a sorted row of cells keyed by id and
// unloads the batch in ascending id order when the last frame arrives.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                   | tlast      | tuser
//  s_axis   | in  | seq_id, payload, payload_length      | last_frame | -
//  m_axis   | out | out_id, out_payload, out_length      | out_last   | overflow
//
//  Collect: one frame per cycle; every cell compares and shifts in the
//  same cycle, regardless of fill.
//  Unload: n results for n stored frames, one per cycle from cell 0 while
//  the output side keeps tready high; s_axis_tready is low during unload.
//  Frames arriving with MAX_FRAMES stored are dropped; overflow rides on
//  every result of that batch. Reset empties the row and the output stage.
// ----------------------------------------------------------------------------
module frame_sort_by_sequence_id
    import fsbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // seq_id, payload, payload_length
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // out_id, out_payload, out_length
    output logic               m_axis_tlast,
    output logic               m_axis_tuser    // overflow
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_EMIT    = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;

    logic              out_valid_reg, out_valid_next;
    logic [ID_W-1:0]   out_id_reg;
    logic [PLD_W-1:0]  out_payload_reg;
    logic [LEN_W-1:0]  out_length_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;

    logic              in_xfer;
    logic              full;
    logic              load_out;
    cell_ctrl_t        ctrl;
    entry_t            new_entry;

    entry_t            cell_entry [MAX_FRAMES];
    logic              cell_take  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_vec;

    assign s_axis_tready = (state_reg == ST_COLLECT);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CNT_W'(MAX_FRAMES));
    assign load_out      = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    assign ctrl.insert = in_xfer && !full;
    assign ctrl.shift  = load_out;

    assign new_entry.valid   = 1'b1;
    assign new_entry.id      = s_axis_tdata[ID_W-1:0];
    assign new_entry.payload = s_axis_tdata[ID_W +: PLD_W] & PAYLOAD_MASK;
    assign new_entry.length  = s_axis_tdata[ID_W + PLD_W +: LEN_W];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_FRAMES; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_t;
            entry_t right_e;

            if (gi == 0)
            begin : g_head
                assign left_e = '0;
                assign left_t = 1'b0;
            end
            else
            begin : g_body
                assign left_e = cell_entry[gi-1];
                assign left_t = cell_take[gi-1];
            end

            if (gi == MAX_FRAMES - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            fsbs_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_take   (left_t),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .take        (cell_take[gi])
            );

            assign valid_vec[gi] = cell_entry[gi].valid;
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_COLLECT:
            begin
                if (in_xfer)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    count_next     = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next   = ST_COLLECT;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output stage: head of the row moves out as the row shifts down
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_id_reg      <= cell_entry[0].id;
            out_payload_reg <= cell_entry[0].payload;
            out_length_reg  <= cell_entry[0].length;
            out_last_reg    <= (count_reg == CNT_W'(1));
            out_ovf_reg     <= dropped_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'({out_length_reg, out_payload_reg, out_id_reg});
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    // occupied cells always match the count, and cell 0 is occupied unless the row is empty
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(valid_vec) == int'(count_reg)) && (valid_vec[0] || (count_reg == '0)))
        else $error("cell occupancy disagrees with frame count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_FRAMES))
        else $error("frame count above row depth");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (count_reg != '0))
        else $error("unload with empty row");

    a_last_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (count_reg == CNT_W'(1))) |=>
            ((state_reg == ST_COLLECT) && (count_reg == '0) && !dropped_reg))
        else $error("batch not closed after final transfer");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for frame_sort_by_sequence_id. Batches of frames are
// streamed in, and a local sorted-insertion model predicts each unloaded
// batch. Stable ordering on equal ids, the store-full drop path and the
// overflow flag are all covered, under several source and sink idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import fsbs_pkg::*;

    localparam int IDLE_LIMIT = 4000;   // cycles with no transfer on either side
    localparam int DRAIN_WAIT = 40;

    typedef struct {
        logic [ID_W-1:0]  id;
        logic [PLD_W-1:0] payload;
        logic [LEN_W-1:0] length;
        logic             last;
    } frame_t;

    typedef struct {
        logic [ID_W-1:0]  id;
        logic [PLD_W-1:0] payload;
        logic [LEN_W-1:0] length;
        logic             last;
        logic             overflow;
    } sorted_frame_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // seq_id, payload, payload_length
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // out_id, out_payload, out_length
    logic               m_axis_tlast;
    logic               m_axis_tuser;        // overflow

    frame_t        pending_frames[$];
    sorted_frame_t sorted_out_q[$];

    // model of the sorted store
    logic [ID_W-1:0]  held_id[MAX_FRAMES];
    logic [PLD_W-1:0] held_payload[MAX_FRAMES];
    logic [LEN_W-1:0] held_length[MAX_FRAMES];
    int               held_count = 0;
    bit               batch_dropped = 1'b0;

    int  send_idle_pct = 0;
    int  sink_stall_pct = 0;
    bit  src_xfer = 1'b0;
    int  idle_cycles = 0;
    int  error_count = 0;
    int  frames_in = 0;
    int  results_out = 0;
    int  batches_out = 0;
    int  overflow_batches = 0;

    frame_sort_by_sequence_id u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // insertion after every entry with id <= new id keeps equal ids in arrival order
    task automatic sort_frame_in(input frame_t f);
        int pos;
        sorted_frame_t r;
        if (held_count >= MAX_FRAMES) begin
            batch_dropped = 1'b1;
        end
        else begin
            pos = held_count;
            while (pos > 0 && held_id[pos-1] > f.id) begin
                held_id[pos]      = held_id[pos-1];
                held_payload[pos] = held_payload[pos-1];
                held_length[pos]  = held_length[pos-1];
                pos--;
            end
            held_id[pos]      = f.id;
            held_payload[pos] = f.payload & PAYLOAD_MASK;
            held_length[pos]  = f.length;
            held_count++;
        end
        if (f.last) begin
            for (int k = 0; k < held_count; k++) begin
                r.id       = held_id[k];
                r.payload  = held_payload[k];
                r.length   = held_length[k];
                r.last     = (k == held_count - 1);
                r.overflow = batch_dropped;
                sorted_out_q.push_back(r);
            end
            held_count    = 0;
            batch_dropped = 1'b0;
        end
    endtask

    // source driver
    always @(negedge clk) begin
        logic   next_valid;
        frame_t f;
        next_valid = s_axis_tvalid;
        if (!rst_n) begin
            next_valid = 1'b0;
        end
        else if (!s_axis_tvalid || src_xfer) begin
            next_valid = 1'b0;
            if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                f = pending_frames.pop_front();
                s_axis_tdata <= TDATA_W'({f.length, f.payload, f.id});
                s_axis_tlast <= f.last;
                next_valid = 1'b1;
            end
        end
        s_axis_tvalid <= next_valid;
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // checker and predictor
    always @(posedge clk) begin
        frame_t        f;
        sorted_frame_t want;
        src_xfer <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            results_out++;
            if (sorted_out_q.size() == 0) begin
                report_mismatch("result count", 64'(results_out), 64'(results_out - 1));
            end
            else begin
                want = sorted_out_q.pop_front();
                if (m_axis_tdata[ID_W-1:0] !== want.id)
                    report_mismatch("out_id", 64'(m_axis_tdata[ID_W-1:0]), 64'(want.id));
                if (m_axis_tdata[ID_W+PLD_W-1:ID_W] !== want.payload)
                    report_mismatch("out_payload", 64'(m_axis_tdata[ID_W+PLD_W-1:ID_W]),
                                    64'(want.payload));
                if (m_axis_tdata[ID_W+PLD_W+LEN_W-1:ID_W+PLD_W] !== want.length)
                    report_mismatch("out_length",
                                    64'(m_axis_tdata[ID_W+PLD_W+LEN_W-1:ID_W+PLD_W]),
                                    64'(want.length));
                if (m_axis_tlast !== want.last)
                    report_mismatch("out_last", 64'(m_axis_tlast), 64'(want.last));
                if (m_axis_tuser !== want.overflow)
                    report_mismatch("overflow", 64'(m_axis_tuser), 64'(want.overflow));
                if (want.last) begin
                    batches_out++;
                    if (want.overflow)
                        overflow_batches++;
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            f.id      = s_axis_tdata[ID_W-1:0];
            f.payload = s_axis_tdata[ID_W+PLD_W-1:ID_W];
            f.length  = s_axis_tdata[ID_W+PLD_W+LEN_W-1:ID_W+PLD_W];
            f.last    = s_axis_tlast;
            frames_in++;
            sort_frame_in(f);
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic push_frame(input logic [ID_W-1:0] id, input logic [PLD_W-1:0] payload,
                              input logic [LEN_W-1:0] length, input logic last);
        frame_t f;
        f.id      = id;
        f.payload = payload;
        f.length  = length;
        f.last    = last;
        pending_frames.push_back(f);
    endtask

    function automatic logic [PLD_W-1:0] rand_payload();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {8'($urandom_range(255)), 32'($urandom)};
    endfunction

    // random batch; a narrow id band forces plenty of equal ids
    task automatic push_rand_batch(output int n);
        int   base;
        bit   narrow;
        bit   odd_len;
        logic [ID_W-1:0] id;
        n = ($urandom_range(99) < 15) ? $urandom_range(MAX_FRAMES + 1, MAX_FRAMES + 6)
                                      : $urandom_range(1, MAX_FRAMES);
        narrow  = ($urandom_range(2) == 0);
        odd_len = ($urandom_range(4) == 0);
        base    = $urandom_range(252);
        for (int i = 0; i < n; i++) begin
            id = narrow ? ID_W'(base + $urandom_range(3)) : ID_W'($urandom_range(255));
            push_frame(id, rand_payload(),
                       odd_len ? LEN_W'($urandom_range(7)) : LEN_W'($urandom_range(1, 5)),
                       i == n - 1);
        end
    endtask

    task automatic drain();
        while (pending_frames.size() != 0 || s_axis_tvalid || sorted_out_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input int frame_budget);
        int pushed;
        int n;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        pushed = 0;
        while (pushed < frame_budget) begin
            push_rand_batch(n);
            pushed += n;
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // equal ids, extreme ids and payloads, out-of-range lengths
        push_frame(8'd255, '1, 3'd5, 1'b0);
        push_frame(8'd0, '0, 3'd1, 1'b0);
        push_frame(8'd7, 40'h01_0203_0405, 3'd0, 1'b0);
        push_frame(8'd7, 40'hAA_AAAA_AAAA, 3'd6, 1'b0);
        push_frame(8'd128, 40'h55_5555_5555, 3'd7, 1'b0);
        push_frame(8'd7, 40'h00_0000_0001, 3'd3, 1'b1);
        // batch of one
        push_frame(8'd0, '1, 3'd5, 1'b1);
        // fill the store in descending order; the marked-last frame is dropped
        for (int i = 0; i <= MAX_FRAMES; i++)
            push_frame(ID_W'(200 - 10 * i), rand_payload(), LEN_W'($urandom_range(1, 5)),
                       i == MAX_FRAMES);
        drain();

        run_random_phase(0, 0, 85);
        run_random_phase(86, 0, 85);
        run_random_phase(0, 86, 85);
        run_random_phase(33, 33, 85);

        repeat (DRAIN_WAIT) @(posedge clk);
        $display("covered %0d frames in, %0d sorted results over %0d batches", frames_in,
                 results_out, batches_out);
        $display("%0d batches overflowed; %0d mismatches", overflow_batches, error_count);
        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
